// ===== design/gsld_pkg.sv =====
// gsld_pkg: shared constants, types and helpers for the support-leg displacement block
`timescale 1ns / 1ps
package gsld_pkg;

   localparam int COUNT_BITS    = 16;
   localparam int POS_FRAC_BITS = 16;

   localparam int MUL_A_W = 19;
   localparam int MUL_B_W = 35;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // quaternion products are Q4.28
   localparam int ROT_SHIFT = 28;

   localparam longint ROOT_Z_MAG = (93 * (longint'(1) << POS_FRAC_BITS) + 50) / 100;
   localparam logic signed [31:0] ROOT_Z_RESET = 32'(-ROOT_Z_MAG);

   localparam logic signed [33:0] SAT_MAX = 34'sh0_7FFF_FFFF;
   localparam logic signed [33:0] SAT_MIN = -34'sh0_8000_0000;

   typedef logic [COUNT_BITS-1:0] count_type;

   // foot phase codes
   localparam logic [1:0] PH_STANCE  = 2'd0;
   localparam logic [1:0] PH_SWING   = 2'd1;
   localparam logic [1:0] PH_UNKNOWN = 2'd3;

   // support leg codes
   localparam logic [1:0] SUP_NONE  = 2'd0;
   localparam logic [1:0] SUP_LEFT  = 2'd1;
   localparam logic [1:0] SUP_RIGHT = 2'd2;

   // item kinds
   localparam logic [2:0] T_LTHIGH = 3'd0;
   localparam logic [2:0] T_LCALF  = 3'd1;
   localparam logic [2:0] T_LFOOT  = 3'd2;
   localparam logic [2:0] T_RTHIGH = 3'd3;
   localparam logic [2:0] T_RCALF  = 3'd4;
   localparam logic [2:0] T_RFOOT  = 3'd5;
   localparam logic [2:0] T_EST    = 3'd6;

   // register indexes
   localparam logic [2:0] REG_THIGH   = 3'd0;
   localparam logic [2:0] REG_SHANK   = 3'd1;
   localparam logic [2:0] REG_ACC_LO  = 3'd2;
   localparam logic [2:0] REG_ACC_HI  = 3'd3;
   localparam logic [2:0] REG_GYRO    = 3'd4;
   localparam logic [2:0] REG_PERSIST = 3'd5;
   localparam logic [2:0] REG_SWITCH  = 3'd6;

   // accumulator destinations of a product
   localparam logic [2:0] D_ASQ = 3'd0;
   localparam logic [2:0] D_GSQ = 3'd1;
   localparam logic [2:0] D_K0  = 3'd2;
   localparam logic [2:0] D_K1  = 3'd3;
   localparam logic [2:0] D_K2  = 3'd4;
   localparam logic [2:0] D_R0  = 3'd5;
   localparam logic [2:0] D_R1  = 3'd6;
   localparam logic [2:0] D_R2  = 3'd7;

   typedef struct packed {
      logic       vld;
      logic [2:0] dst;
      logic       neg;
      logic       idx;
   } mul_tag_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > SAT_MAX) return 32'sh7FFF_FFFF;
      if (v < SAT_MIN) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic count_type inc_sat(input count_type c);
      return (c == '1) ? c : count_type'(c + 1'b1);
   endfunction

endpackage

// ===== design/gait_support_leg_displacement.sv =====
// gait_support_leg_displacement: foot stance detection, support-leg choice and root position
`timescale 1ns / 1ps
// Segment items (thigh/calf quaternions, foot acceleration and rate) are stored on
// acceptance, and the input stays ready. An estimate item runs 12 squaring steps for
// the foot norms, a classification step, and 44 steps that rotate the four leg
// segments (8 quaternion products and 3 length scalings each), all through one 19x35
// signed multiplier with a registered product, plus the drain states S_SQW and S_ROTW
// and the position update. req_tready is low while an estimate is in progress. The
// result waits in an output register, so the next item is taken while it is still pending.
module gait_support_leg_displacement
   import gsld_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // quat_x, quat_y, quat_z, quat_w, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z
   input  logic [159:0] req_tdata,
   // req_type
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // root_x, root_y, root_z, support, left_stance, right_stance, zero pad
   output logic [103:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SQ   = 3'd1;
   localparam logic [2:0] S_SQW  = 3'd2;
   localparam logic [2:0] S_CLS  = 3'd3;
   localparam logic [2:0] S_ROT  = 3'd4;
   localparam logic [2:0] S_ROTW = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0]  state_ff;
   logic [1:0]  idx_ff;
   logic [3:0]  step_ff;

   logic [17:0] thigh_ff, shank_ff;
   logic [31:0] acc_low_ff, acc_high_ff, gyro_lim_ff;
   logic [7:0]  persist_ff, switch_ff;

   logic signed [15:0] quat_ff [0:3][0:3];
   logic signed [15:0] foot_ff [0:1][0:5];

   count_type   acc_run_ff [0:1];
   count_type   gyr_run_ff [0:1];
   count_type   sup_run_ff [0:1];
   logic [1:0]  phase_ff [0:1];
   logic [1:0]  prev_ff, sup_ff;

   logic signed [31:0] anchor_ff [0:2];
   logic signed [31:0] offs_ff [0:1][0:2];
   logic signed [31:0] root_ff [0:2];

   logic [31:0]        asq_ff [0:1];
   logic [31:0]        gsq_ff [0:1];
   logic signed [34:0] k_ff [0:2];
   logic signed [31:0] hip_ff [0:2];
   logic signed [31:0] oth_ff [0:2];

   logic        rsp_valid_ff, rsp_l_ff, rsp_r_ff;
   logic [1:0]  rsp_sup_ff;

   logic                      req_go, out_go;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   mul_tag_type               tag_in, tag_q;
   logic signed [PROD_W-1:0]  prod_q;

   assign req_tready = (state_ff == S_IDLE);
   assign req_go     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_go     = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_r_ff, rsp_l_ff, rsp_sup_ff, root_ff[2], root_ff[1],
                        root_ff[0]};

   // ---------------- operand sequencing ----------------
   logic signed [15:0] qx, qy, qz, qw, fm;
   logic [17:0]        seg_len;

   always_comb begin
      qx      = quat_ff[idx_ff][0];
      qy      = quat_ff[idx_ff][1];
      qz      = quat_ff[idx_ff][2];
      qw      = quat_ff[idx_ff][3];
      fm      = foot_ff[idx_ff[0]][step_ff[2:0]];
      seg_len = idx_ff[0] ? shank_ff : thigh_ff;
      mul_a   = '0;
      mul_b   = '0;
      tag_in  = '0;
      if (state_ff == S_SQ) begin
         mul_a      = MUL_A_W'(fm);
         mul_b      = MUL_B_W'(fm);
         tag_in.vld = 1'b1;
         tag_in.dst = (step_ff < 4'd3) ? D_ASQ : D_GSQ;
         tag_in.idx = idx_ff[0];
      end else if (state_ff == S_ROT) begin
         tag_in.vld = 1'b1;
         // left segments feed the hip sum when left supports, right ones when right does
         tag_in.idx = idx_ff[1] ? (sup_ff == SUP_RIGHT) : (sup_ff == SUP_LEFT);
         case (step_ff)
            4'd0: begin mul_a = MUL_A_W'(qx); mul_b = MUL_B_W'(qz); tag_in.dst = D_K0; end
            4'd1: begin mul_a = MUL_A_W'(qw); mul_b = MUL_B_W'(qy); tag_in.dst = D_K0; end
            4'd2: begin mul_a = MUL_A_W'(qy); mul_b = MUL_B_W'(qz); tag_in.dst = D_K1; end
            4'd3: begin
               mul_a = MUL_A_W'(qw); mul_b = MUL_B_W'(qx);
               tag_in.dst = D_K1; tag_in.neg = 1'b1;
            end
            4'd4: begin mul_a = MUL_A_W'(qw); mul_b = MUL_B_W'(qw); tag_in.dst = D_K2; end
            4'd5: begin
               mul_a = MUL_A_W'(qx); mul_b = MUL_B_W'(qx);
               tag_in.dst = D_K2; tag_in.neg = 1'b1;
            end
            4'd6: begin
               mul_a = MUL_A_W'(qy); mul_b = MUL_B_W'(qy);
               tag_in.dst = D_K2; tag_in.neg = 1'b1;
            end
            4'd7: begin mul_a = MUL_A_W'(qz); mul_b = MUL_B_W'(qz); tag_in.dst = D_K2; end
            4'd8: begin
               mul_a = MUL_A_W'({1'b0, seg_len}); mul_b = {k_ff[0][33:0], 1'b0};
               tag_in.dst = D_R0; tag_in.neg = 1'b1;
            end
            4'd9: begin
               mul_a = MUL_A_W'({1'b0, seg_len}); mul_b = {k_ff[1][33:0], 1'b0};
               tag_in.dst = D_R1; tag_in.neg = 1'b1;
            end
            4'd10: begin
               mul_a = MUL_A_W'({1'b0, seg_len}); mul_b = k_ff[2];
               tag_in.dst = D_R2; tag_in.neg = 1'b1;
            end
            default: tag_in = '0;
         endcase
      end
   end

   gsld_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .a       (mul_a),
      .b       (mul_b),
      .tag_in  (tag_in),
      .prod_ff (prod_q),
      .tag_ff  (tag_q)
   );

   // signed product and its rounded Q16.16 form
   logic signed [PROD_W-1:0] sprod, rsum;
   logic signed [31:0]       rnd;

   always_comb begin
      sprod = tag_q.neg ? -prod_q : prod_q;
      rsum  = sprod + (PROD_W'(1) <<< (ROT_SHIFT - 1));
      rnd   = 32'(rsum >>> ROT_SHIFT);
   end

   // ---------------- foot classification and support choice ----------------
   count_type  acc_run_in [0:1];
   count_type  gyr_run_in [0:1];
   count_type  sup_run_in [0:1];
   logic [1:0] ph_in [0:1];
   logic [1:0] sup_in;
   logic       acc_st, gyr_st;

   function automatic logic [1:0] toggle_sup(input logic [1:0] s);
      case (s)
         SUP_LEFT:  return SUP_RIGHT;
         SUP_RIGHT: return SUP_LEFT;
         default:   return s;
      endcase
   endfunction

   always_comb begin
      for (int f = 0; f < 2; f++) begin
         acc_st = (asq_ff[f] > acc_low_ff) && (asq_ff[f] < acc_high_ff);
         gyr_st = gsq_ff[f] < gyro_lim_ff;
         gyr_run_in[f] = gyr_run_ff[f];
         if (acc_st) begin
            acc_run_in[f] = inc_sat(acc_run_ff[f]);
            if (gyr_st) begin
               gyr_run_in[f] = inc_sat(gyr_run_ff[f]);
               ph_in[f] = PH_STANCE;
            end else begin
               ph_in[f] = ((acc_run_in[f] > count_type'(persist_ff)) ||
                           (gyr_run_ff[f] > count_type'(persist_ff))) ? PH_STANCE : PH_SWING;
               gyr_run_in[f] = '0;
            end
         end else begin
            acc_run_in[f] = '0;
            gyr_run_in[f] = gyr_st ? inc_sat(gyr_run_ff[f]) : '0;
            ph_in[f]      = PH_SWING;
         end
      end

      sup_in        = prev_ff;
      sup_run_in[0] = sup_run_ff[0];
      sup_run_in[1] = sup_run_ff[1];
      if (ph_in[0] == PH_STANCE) begin
         sup_run_in[0] = inc_sat(sup_run_ff[0]);
         if (ph_in[1] == PH_STANCE) begin
            sup_run_in[1] = inc_sat(sup_run_ff[1]);
            if (sup_run_in[1] < sup_run_in[0]) sup_in = SUP_LEFT;
            else if (sup_run_in[1] > sup_run_in[0]) sup_in = SUP_RIGHT;
            else sup_in = toggle_sup(prev_ff);
         end else begin
            sup_run_in[1] = '0;
            sup_in        = SUP_LEFT;
         end
      end else begin
         if (ph_in[1] == PH_STANCE) begin
            sup_run_in[1] = inc_sat(sup_run_ff[1]);
            sup_in        = SUP_RIGHT;
         end else begin
            // both feet swing: after one foot's stance, hand over only after a long enough run
            if (phase_ff[1] == PH_STANCE && phase_ff[0] == PH_SWING)
               sup_in = (sup_run_ff[1] < count_type'(switch_ff)) ? prev_ff : SUP_LEFT;
            else if (phase_ff[0] == PH_STANCE && phase_ff[1] == PH_SWING)
               sup_in = (sup_run_ff[0] < count_type'(switch_ff)) ? prev_ff : SUP_RIGHT;
            else if (phase_ff[0] == PH_STANCE && phase_ff[1] == PH_STANCE)
               sup_in = toggle_sup(prev_ff);
            else
               sup_in = prev_ff;
            sup_run_in[1] = '0;
         end
         sup_run_in[0] = '0;
      end
   end

   // ---------------- position update ----------------
   logic               change, own, other;
   logic signed [31:0] anchor_in [0:2];
   logic signed [31:0] ank_in [0:2];
   logic signed [31:0] root_in [0:2];

   always_comb begin
      change = ((prev_ff == SUP_LEFT) && (sup_ff == SUP_RIGHT)) ||
               ((prev_ff == SUP_RIGHT) && (sup_ff == SUP_LEFT));
      own    = (sup_ff != SUP_LEFT);
      other  = (sup_ff == SUP_LEFT);
      for (int i = 0; i < 3; i++) begin
         ank_in[i] = sat32(34'(hip_ff[i]) - 34'(oth_ff[i]));
         if (!change) anchor_in[i] = anchor_ff[i];
         else if (i == 2) anchor_in[i] = '0;
         else anchor_in[i] = sat32(34'(anchor_ff[i]) + 34'(offs_ff[own][i]));
         root_in[i] = sat32(34'(hip_ff[i]) + 34'(anchor_in[i]));
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         step_ff      <= '0;
         thigh_ff     <= 18'd28180;
         shank_ff     <= 18'd32768;
         acc_low_ff   <= 32'd5242880;
         acc_high_ff  <= 32'd7864320;
         gyro_lim_ff  <= 32'd2097152;
         persist_ff   <= 8'd20;
         switch_ff    <= 8'd15;
         prev_ff      <= SUP_NONE;
         sup_ff       <= SUP_NONE;
         rsp_valid_ff <= 1'b0;
         rsp_sup_ff   <= SUP_NONE;
         rsp_l_ff     <= 1'b0;
         rsp_r_ff     <= 1'b0;
         for (int s = 0; s < 4; s++) begin
            for (int c = 0; c < 4; c++) quat_ff[s][c] <= (c == 3) ? 16'sd16384 : 16'sd0;
         end
         for (int f = 0; f < 2; f++) begin
            for (int c = 0; c < 6; c++) foot_ff[f][c] <= '0;
            for (int i = 0; i < 3; i++) offs_ff[f][i] <= '0;
            acc_run_ff[f] <= '0;
            gyr_run_ff[f] <= '0;
            sup_run_ff[f] <= '0;
            phase_ff[f]   <= PH_UNKNOWN;
         end
         for (int i = 0; i < 3; i++) begin
            anchor_ff[i] <= '0;
            root_ff[i]   <= (i == 2) ? ROOT_Z_RESET : 32'sd0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_THIGH:   thigh_ff    <= csr_data[17:0];
               REG_SHANK:   shank_ff    <= csr_data[17:0];
               REG_ACC_LO:  acc_low_ff  <= csr_data;
               REG_ACC_HI:  acc_high_ff <= csr_data;
               REG_GYRO:    gyro_lim_ff <= csr_data;
               REG_PERSIST: persist_ff  <= csr_data[7:0];
               REG_SWITCH:  switch_ff   <= csr_data[7:0];
               default:     ;
            endcase
         end

         if (rsp_valid_ff && rsp_tready && !out_go) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (req_go) begin
                  if (req_tuser inside {T_LTHIGH, T_LCALF, T_RTHIGH, T_RCALF}) begin
                     for (int c = 0; c < 4; c++)
                        quat_ff[(req_tuser < T_RTHIGH) ? req_tuser[1:0] :
                                2'(req_tuser - 3'd1)][c] <= req_tdata[16*c +: 16];
                  end else if (req_tuser == T_LFOOT || req_tuser == T_RFOOT) begin
                     for (int c = 0; c < 6; c++)
                        foot_ff[req_tuser == T_RFOOT][c] <= req_tdata[64 + 16*c +: 16];
                  end else if (req_tuser == T_EST) begin
                     idx_ff   <= '0;
                     step_ff  <= '0;
                     state_ff <= S_SQ;
                  end
               end
            end
            S_SQ: begin
               if (step_ff == 4'd5) begin
                  step_ff <= '0;
                  if (idx_ff == 2'd1) state_ff <= S_SQW;
                  else idx_ff <= idx_ff + 2'd1;
               end else begin
                  step_ff <= step_ff + 4'd1;
               end
            end
            S_SQW: state_ff <= S_CLS;
            S_CLS: begin
               for (int f = 0; f < 2; f++) begin
                  acc_run_ff[f] <= acc_run_in[f];
                  gyr_run_ff[f] <= gyr_run_in[f];
                  sup_run_ff[f] <= sup_run_in[f];
                  phase_ff[f]   <= ph_in[f];
               end
               sup_ff   <= sup_in;
               idx_ff   <= '0;
               step_ff  <= '0;
               state_ff <= S_ROT;
            end
            S_ROT: begin
               if (step_ff == 4'd10) begin
                  step_ff <= '0;
                  if (idx_ff == 2'd3) state_ff <= S_ROTW;
                  else idx_ff <= idx_ff + 2'd1;
               end else begin
                  step_ff <= step_ff + 4'd1;
               end
            end
            S_ROTW: state_ff <= S_OUT;
            S_OUT: begin
               if (out_go) begin
                  if (sup_ff == SUP_LEFT || sup_ff == SUP_RIGHT) begin
                     for (int i = 0; i < 3; i++) begin
                        anchor_ff[i]       <= anchor_in[i];
                        offs_ff[other][i]  <= ank_in[i];
                        root_ff[i]         <= root_in[i];
                     end
                  end
                  prev_ff      <= sup_ff;
                  rsp_sup_ff   <= sup_ff;
                  rsp_l_ff     <= (phase_ff[0] == PH_STANCE);
                  rsp_r_ff     <= (phase_ff[1] == PH_STANCE);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // accumulators, cleared at the start of each pass
   always_ff @(posedge clock) begin
      if (req_go && req_tuser == T_EST) begin
         for (int f = 0; f < 2; f++) begin
            asq_ff[f] <= '0;
            gsq_ff[f] <= '0;
         end
      end
      if (state_ff == S_CLS) begin
         for (int i = 0; i < 3; i++) begin
            hip_ff[i] <= '0;
            oth_ff[i] <= '0;
         end
      end
      // a new segment starts its k sums while the previous one drains into hip/oth
      if (state_ff == S_ROT && step_ff == 4'd0) begin
         for (int i = 0; i < 3; i++) k_ff[i] <= '0;
      end
      if (tag_q.vld) begin
         case (tag_q.dst)
            D_ASQ: asq_ff[tag_q.idx] <= asq_ff[tag_q.idx] + sprod[31:0];
            D_GSQ: gsq_ff[tag_q.idx] <= gsq_ff[tag_q.idx] + sprod[31:0];
            D_K0:  k_ff[0] <= k_ff[0] + sprod[34:0];
            D_K1:  k_ff[1] <= k_ff[1] + sprod[34:0];
            D_K2:  k_ff[2] <= k_ff[2] + sprod[34:0];
            D_R0: begin
               if (tag_q.idx) hip_ff[0] <= hip_ff[0] + rnd;
               else oth_ff[0] <= oth_ff[0] + rnd;
            end
            D_R1: begin
               if (tag_q.idx) hip_ff[1] <= hip_ff[1] + rnd;
               else oth_ff[1] <= oth_ff[1] + rnd;
            end
            D_R2: begin
               if (tag_q.idx) hip_ff[2] <= hip_ff[2] + rnd;
               else oth_ff[2] <= oth_ff[2] + rnd;
            end
            default: ;
         endcase
      end
   end

`ifndef SYNTHESIS
   // products only come back while a pass is running or draining
   assert property (@(posedge clock) disable iff (reset)
      tag_q.vld |-> (state_ff == S_SQW || state_ff == S_SQ || state_ff == S_CLS ||
                     state_ff == S_ROT || state_ff == S_ROTW || state_ff == S_OUT))
      else $error("product returned outside a pass");

   // finishing an estimate presents a word and frees the input side
   assert property (@(posedge clock) disable iff (reset)
      out_go |=> (rsp_tvalid && state_ff == S_IDLE))
      else $error("estimate finished without a response word");

   // the chosen support leg is never the unused code
   assert property (@(posedge clock) disable iff (reset)
      (sup_ff != 2'd3) && (prev_ff != 2'd3))
      else $error("support leg code out of range");

   // no new item is taken while an estimate is in flight
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("input taken during an estimate");
`endif

endmodule

// ===== design/gsld_mul.sv =====
// gsld_mul: shared signed multiplier with registered product and destination tag
`timescale 1ns / 1ps
module gsld_mul
   import gsld_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [MUL_A_W-1:0] a,
   input  logic signed [MUL_B_W-1:0] b,
   input  mul_tag_type               tag_in,
   output logic signed [PROD_W-1:0]  prod_ff,
   output mul_tag_type               tag_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

endmodule

// ===== test/gait_support_leg_displacement_test.sv =====
// gait_support_leg_displacement_test: self-checking stream testbench with a stance predictor
`timescale 1ns / 1ps
module gait_support_leg_displacement_test
   import gsld_pkg::*;
;

   localparam logic [2:0] T_IGNORED = 3'd7;
   localparam logic [2:0] REG_BEYOND = 3'd7;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic [2:0]         kind;
      logic signed [15:0] q[4];
      logic signed [15:0] m[6];
   } leg_word_type;

   typedef struct {
      logic signed [31:0] root[3];
      logic [1:0]         sup;
      logic               lst;
      logic               rst;
   } pose_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [103:0] rsp_tdata;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   gait_support_leg_displacement DUT (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // predictor state
   longint     thigh_len, shank_len, acc_lo, acc_hi, gyro_lim, persist_cnt, switch_cnt;
   logic signed [15:0] seg_q[16];
   logic signed [15:0] foot_m[12];
   longint     acc_run[2], gyro_run[2], sup_run[2];
   logic [1:0] prev_phase[2];
   logic [1:0] sup_prev;
   longint     anchor[3], ankle_ofs[6], root_p[3];

   leg_word_type pending_words[$];
   pose_type     pending_poses[$];
   int         mismatches = 0, poses_seen = 0, estimates = 0, handovers = 0, stances = 0;
   logic       req_fire = 0, rsp_fire = 0, csr_fire = 0;
   int         req_gap = 0, rsp_stall = 0;
   bit         hold_req = 1;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint bump(longint c);
      return (c >= (64'sd1 << COUNT_BITS) - 1) ? (64'sd1 << COUNT_BITS) - 1 : c + 1;
   endfunction

   function automatic logic [1:0] swap_leg(logic [1:0] s);
      return s == SUP_LEFT ? SUP_RIGHT : (s == SUP_RIGHT ? SUP_LEFT : s);
   endfunction

   function automatic void rotate_seg(int seg, longint len, output longint o[3]);
      longint x, y, z, w, k[3];
      x = seg_q[seg*4];
      y = seg_q[seg*4+1];
      z = seg_q[seg*4+2];
      w = seg_q[seg*4+3];
      k[0] = 2 * (x*z + w*y);
      k[1] = 2 * (y*z - w*x);
      k[2] = w*w - x*x - y*y + z*z;
      for (int i = 0; i < 3; i++) o[i] = (-(len * k[i]) + (64'sd1 << 27)) >>> ROT_SHIFT;
   endfunction

   function automatic logic [1:0] foot_phase_of(int f);
      longint asq, gsq;
      bit acc_st, gyr_st;
      logic [1:0] ph;
      asq = 0;
      gsq = 0;
      for (int i = 0; i < 3; i++) begin
         asq += longint'(foot_m[f*6+i]) * foot_m[f*6+i];
         gsq += longint'(foot_m[f*6+3+i]) * foot_m[f*6+3+i];
      end
      acc_st = asq > acc_lo && asq < acc_hi;
      gyr_st = gsq < gyro_lim;
      if (acc_st) begin
         acc_run[f] = bump(acc_run[f]);
         if (gyr_st) begin
            gyro_run[f] = bump(gyro_run[f]);
            ph = PH_STANCE;
         end else begin
            ph = (acc_run[f] > persist_cnt || gyro_run[f] > persist_cnt) ? PH_STANCE : PH_SWING;
            gyro_run[f] = 0;
         end
      end else begin
         acc_run[f] = 0;
         gyro_run[f] = gyr_st ? bump(gyro_run[f]) : 0;
         ph = PH_SWING;
      end
      return ph;
   endfunction

   function automatic void reset_model();
      thigh_len = 28180; shank_len = 32768;
      acc_lo = 5242880; acc_hi = 7864320; gyro_lim = 2097152;
      persist_cnt = 20; switch_cnt = 15;
      for (int i = 0; i < 16; i++) seg_q[i] = (i % 4 == 3) ? 16'sd16384 : 16'sd0;
      foreach (foot_m[i]) foot_m[i] = 0;
      for (int i = 0; i < 2; i++) begin
         acc_run[i] = 0; gyro_run[i] = 0; sup_run[i] = 0; prev_phase[i] = PH_UNKNOWN;
      end
      sup_prev = SUP_NONE;
      for (int i = 0; i < 3; i++) begin anchor[i] = 0; root_p[i] = 0; end
      foreach (ankle_ofs[i]) ankle_ofs[i] = 0;
      root_p[2] = ROOT_Z_RESET;
   endfunction

   // full step of the estimator for one estimate word
   function automatic pose_type estimate_pose();
      logic [1:0] l, r, pl, pr, pre, sup;
      longint lt[3], lc[3], rt[3], rc[3], hip, ank;
      pose_type p;
      l = foot_phase_of(0);
      r = foot_phase_of(1);
      pl = prev_phase[0];
      pr = prev_phase[1];
      pre = sup_prev;
      sup = pre;
      if (l == PH_STANCE) begin
         sup_run[0] = bump(sup_run[0]);
         if (r == PH_STANCE) begin
            sup_run[1] = bump(sup_run[1]);
            if (sup_run[1] < sup_run[0]) sup = SUP_LEFT;
            else if (sup_run[1] > sup_run[0]) sup = SUP_RIGHT;
            else sup = swap_leg(pre);
         end else begin
            sup_run[1] = 0;
            sup = SUP_LEFT;
         end
      end else begin
         if (r == PH_STANCE) begin
            sup_run[1] = bump(sup_run[1]);
            sup = SUP_RIGHT;
         end else begin
            if (pr == PH_STANCE && pl == PH_SWING)
               sup = (sup_run[1] < switch_cnt) ? pre : SUP_LEFT;
            else if (pl == PH_STANCE && pr == PH_SWING)
               sup = (sup_run[0] < switch_cnt) ? pre : SUP_RIGHT;
            else if (pl == PH_STANCE && pr == PH_STANCE)
               sup = swap_leg(pre);
            sup_run[1] = 0;
         end
         sup_run[0] = 0;
      end
      rotate_seg(0, thigh_len, lt);
      rotate_seg(1, shank_len, lc);
      rotate_seg(2, thigh_len, rt);
      rotate_seg(3, shank_len, rc);
      if (sup == SUP_LEFT || sup == SUP_RIGHT) begin
         if ((pre == SUP_LEFT && sup == SUP_RIGHT) || (pre == SUP_RIGHT && sup == SUP_LEFT))
            handovers++;
         for (int i = 0; i < 3; i++) begin
            if (sup == SUP_LEFT) begin
               hip = lc[i] + lt[i];
               ank = hip - rt[i] - rc[i];
            end else begin
               hip = rc[i] + rt[i];
               ank = hip - lt[i] - lc[i];
            end
            // handover: anchor jumps to the new support ankle, height cleared
            if ((pre == SUP_LEFT && sup == SUP_RIGHT) || (pre == SUP_RIGHT && sup == SUP_LEFT))
               anchor[i] = (i == 2) ? 0 :
                  clamp32(anchor[i] + ankle_ofs[(sup == SUP_LEFT ? 0 : 3) + i]);
            ankle_ofs[(sup == SUP_LEFT ? 3 : 0) + i] = clamp32(ank);
            root_p[i] = clamp32(hip + anchor[i]);
         end
      end
      sup_prev = sup;
      prev_phase[0] = l;
      prev_phase[1] = r;
      for (int i = 0; i < 3; i++) p.root[i] = root_p[i][31:0];
      p.sup = sup;
      p.lst = (l == PH_STANCE);
      p.rst = (r == PH_STANCE);
      if (p.lst || p.rst) stances++;
      return p;
   endfunction

   function automatic void absorb_word(leg_word_type w);
      int seg;
      case (w.kind)
         T_LTHIGH, T_LCALF, T_RTHIGH, T_RCALF: begin
            seg = (w.kind < T_LFOOT) ? w.kind : w.kind - 1;
            for (int i = 0; i < 4; i++) seg_q[seg*4+i] = w.q[i];
         end
         T_LFOOT, T_RFOOT: begin
            for (int i = 0; i < 6; i++) foot_m[(w.kind == T_LFOOT ? 0 : 6) + i] = w.m[i];
         end
         T_EST: begin
            estimates++;
            pending_poses.push_back(estimate_pose());
         end
         default: ;
      endcase
   endfunction

   function automatic void apply_csr(logic [2:0] idx, logic [31:0] v);
      case (idx)
         REG_THIGH:   thigh_len = v[17:0];
         REG_SHANK:   shank_len = v[17:0];
         REG_ACC_LO:  acc_lo = v;
         REG_ACC_HI:  acc_hi = v;
         REG_GYRO:    gyro_lim = v;
         REG_PERSIST: persist_cnt = v[7:0];
         REG_SWITCH:  switch_cnt = v[7:0];
         default: ;
      endcase
   endfunction

   // sampling at the rising edge: handshakes, prediction and checking
   always @(posedge clock) begin
      pose_type e;
      pose_type a;
      req_fire <= !reset && req_tvalid && req_tready;
      rsp_fire <= !reset && rsp_tvalid && rsp_tready;
      csr_fire <= !reset && csr_valid && csr_ready;
      if (!reset && csr_valid && csr_ready) apply_csr(csr_index, csr_data);
      if (!reset && req_tvalid && req_tready) begin
         leg_word_type w;
         w.kind = req_tuser;
         for (int i = 0; i < 4; i++) w.q[i] = req_tdata[16*i +: 16];
         for (int i = 0; i < 6; i++) w.m[i] = req_tdata[64 + 16*i +: 16];
         absorb_word(w);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.root[0] = rsp_tdata[31:0];
         a.root[1] = rsp_tdata[63:32];
         a.root[2] = rsp_tdata[95:64];
         a.sup = rsp_tdata[97:96];
         a.lst = rsp_tdata[98];
         a.rst = rsp_tdata[99];
         poses_seen++;
         if (pending_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", rsp_tdata);
         end else begin
            e = pending_poses.pop_front();
            if (e.root != a.root || e.sup != a.sup || e.lst != a.lst || e.rst != a.rst) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: exp root %0d %0d %0d sup %0d st %b%b,",
                     poses_seen, e.root[0], e.root[1], e.root[2], e.sup, e.lst, e.rst,
                     " got %0d %0d %0d sup %0d st %b%b",
                     a.root[0], a.root[1], a.root[2], a.sup, a.lst, a.rst);
            end
         end
      end
   end

   function automatic int pick_gap();
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
   endfunction

   // input driver: words leave the pending queue at the falling edge
   always @(negedge clock) begin
      leg_word_type w;
      if (!reset) begin
         if (req_tvalid && !req_fire) begin
            // still waiting for the handshake
         end else if (req_tvalid && req_fire && req_gap == 0 && pending_words.size() > 0 &&
                      !hold_req) begin
            w = pending_words.pop_front();
            req_tuser <= w.kind;
            for (int i = 0; i < 4; i++) req_tdata[16*i +: 16] <= w.q[i];
            for (int i = 0; i < 6; i++) req_tdata[64 + 16*i +: 16] <= w.m[i];
            req_gap <= pick_gap();
         end else if (req_tvalid) begin
            req_tvalid <= 0;
         end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
         end else if (pending_words.size() > 0 && !hold_req) begin
            w = pending_words.pop_front();
            req_tuser <= w.kind;
            for (int i = 0; i < 4; i++) req_tdata[16*i +: 16] <= w.q[i];
            for (int i = 0; i < 6; i++) req_tdata[64 + 16*i +: 16] <= w.m[i];
            req_tvalid <= 1;
            req_gap <= pick_gap();
         end
         // result side stalls
         if (rsp_fire && rsp_stall == 0) begin
            rsp_stall <= pick_gap();
            rsp_tready <= 0;
         end else if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_tready <= (rsp_stall == 1);
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   function automatic int span(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic leg_word_type quat_word(logic [2:0] kind, bit full);
      leg_word_type w;
      w.kind = kind;
      for (int i = 0; i < 4; i++) w.q[i] = full ? 16'($urandom) : 16'(span(-12000, 12000));
      for (int i = 0; i < 6; i++) w.m[i] = 16'($urandom);
      if (!full) w.q[3] = 16'(span(8000, 16384));
      return w;
   endfunction

   // stance-like feet sit near gravity with a slow spin
   function automatic leg_word_type foot_word(logic [2:0] kind, bit planted);
      leg_word_type w;
      w.kind = kind;
      for (int i = 0; i < 4; i++) w.q[i] = 16'($urandom);
      if (planted) begin
         w.m[0] = 16'(span(-300, 300));
         w.m[1] = 16'(span(-300, 300));
         w.m[2] = 16'(span(2300, 2750) * ($urandom_range(0, 5) == 0 ? -1 : 1));
         for (int i = 3; i < 6; i++)
            w.m[i] = ($urandom_range(0, 9) == 0) ? 16'(span(-4000, 4000))
                                                 : 16'(span(-400, 400));
      end else begin
         for (int i = 0; i < 6; i++) w.m[i] = 16'($urandom);
         if ($urandom_range(0, 1)) w.m[2] = 16'(span(0, 1800));
      end
      return w;
   endfunction

   function automatic leg_word_type bare_word(logic [2:0] kind);
      leg_word_type w;
      w.kind = kind;
      for (int i = 0; i < 4; i++) w.q[i] = 16'($urandom);
      for (int i = 0; i < 6; i++) w.m[i] = 16'($urandom);
      return w;
   endfunction

   task automatic write_csr(logic [2:0] idx, logic [31:0] v);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= v;
      csr_valid <= 1;
      do @(negedge clock); while (!csr_fire);
      csr_valid <= 0;
   endtask

   task automatic let_drain();
      hold_req = 0;
      wait (pending_words.size() == 0);
      @(negedge clock);
      while (req_tvalid || pending_poses.size() > 0) @(negedge clock);
      hold_req = 1;
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic random_traffic(int words);
      bit planted[2];
      int n;
      leg_word_type w;
      planted[0] = $urandom_range(0, 1);
      planted[1] = $urandom_range(0, 1);
      n = 0;
      while (n < words) begin
         if ($urandom_range(0, 12) == 0) begin
            // noise: ignored kind or a stray word
            w = bare_word($urandom_range(0, 1) ? T_IGNORED : 3'($urandom_range(0, 6)));
            pending_words.push_back(w);
            n++;
         end
         for (int f = 0; f < 2; f++) if ($urandom_range(0, 11) == 0) planted[f] = !planted[f];
         if ($urandom_range(0, 2) == 0) begin
            w = quat_word(3'(T_LTHIGH + 0), $urandom_range(0, 3) == 0);
            w.kind = ($urandom_range(0, 1)) ? ($urandom_range(0, 1) ? T_LTHIGH : T_LCALF)
                                            : ($urandom_range(0, 1) ? T_RTHIGH : T_RCALF);
            pending_words.push_back(w);
            n++;
         end
         if ($urandom_range(0, 7) != 0) begin
            pending_words.push_back(foot_word(T_LFOOT, planted[0]));
            n++;
         end
         if ($urandom_range(0, 7) != 0) begin
            pending_words.push_back(foot_word(T_RFOOT, planted[1]));
            n++;
         end
         pending_words.push_back(bare_word(T_EST));
         n++;
      end
   endtask

   initial begin
      leg_word_type w;
      reset_model();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: no support yet, ignored kinds, extreme quaternions and motion
      pending_words.push_back(bare_word(T_EST));
      pending_words.push_back(bare_word(T_IGNORED));
      w = bare_word(T_LTHIGH); foreach (w.q[i]) w.q[i] = 16'sh8000; pending_words.push_back(w);
      w = bare_word(T_LCALF);  foreach (w.q[i]) w.q[i] = 16'sh7FFF; pending_words.push_back(w);
      w = bare_word(T_RTHIGH); w.q = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000};
      pending_words.push_back(w);
      pending_words.push_back(quat_word(T_RCALF, 0));
      w = bare_word(T_LFOOT);
      w.m = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000};
      pending_words.push_back(w);
      pending_words.push_back(foot_word(T_RFOOT, 1));
      pending_words.push_back(bare_word(T_EST));
      pending_words.push_back(foot_word(T_LFOOT, 1));
      pending_words.push_back(bare_word(T_EST));
      pending_words.push_back(bare_word(T_EST));
      pending_words.push_back(foot_word(T_RFOOT, 0));
      pending_words.push_back(bare_word(T_EST));
      pending_words.push_back(foot_word(T_LFOOT, 0));
      pending_words.push_back(bare_word(T_EST));
      pending_words.push_back(bare_word(T_EST));
      let_drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: ;
            1: begin
               write_csr(REG_THIGH, 32'h3FFFF);
               write_csr(REG_SHANK, 32'h3FFFF);
               write_csr(REG_ACC_LO, 32'h0);
               write_csr(REG_ACC_HI, 32'hFFFF_FFFF);
               write_csr(REG_GYRO, 32'hFFFF_FFFF);
               write_csr(REG_PERSIST, 32'h0);
               write_csr(REG_SWITCH, 32'h0);
               write_csr(REG_BEYOND, $urandom);
            end
            2: begin
               write_csr(REG_THIGH, 32'h0);
               write_csr(REG_SHANK, 32'h0);
               write_csr(REG_ACC_LO, 32'd5000000);
               write_csr(REG_ACC_HI, 32'd8000000);
               write_csr(REG_GYRO, 32'd1000000);
               write_csr(REG_PERSIST, 32'hFF);
               write_csr(REG_SWITCH, 32'hFF);
            end
            default: begin
               write_csr(REG_THIGH, $urandom_range(0, 262143));
               write_csr(REG_SHANK, $urandom_range(0, 262143));
               write_csr(REG_ACC_LO, $urandom_range(3000000, 6000000));
               write_csr(REG_ACC_HI, $urandom_range(7000000, 12000000));
               write_csr(REG_GYRO, $urandom_range(500000, 4000000));
               write_csr(REG_PERSIST, $urandom_range(0, 30));
               write_csr(REG_SWITCH, $urandom_range(0, 25));
            end
         endcase
         random_traffic(255);
         let_drain();
      end

      $display("%0d estimates checked, %0d support handovers, %0d with a foot in stance",
               estimates, handovers, stances);
      $display("%0d result words compared over six register settings", poses_seen);
      if (mismatches == 0 && pending_poses.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
